### rtl/core/decimal_string_to_fixed_defines.svh
// assertion macros for the decimal string parser
`ifndef DECIMAL_STRING_TO_FIXED_DEFINES_SVH
`define DECIMAL_STRING_TO_FIXED_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define DSTF_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dstf check failed");
// checked in every cycle, reset included
`define DSTF_CHECK_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dstf check failed");
`else
`define DSTF_CHECK(lbl, prop)
`define DSTF_CHECK_ALWAYS(lbl, prop)
`endif

`endif

### rtl/core/dstf_pkg.sv
package dstf_pkg;

  localparam int FRAC_PLACES = 2;
  localparam int VALUE_BITS  = 32;
  localparam int FRAC_BITS   = $clog2(FRAC_PLACES + 2);
  // 10^6 fits in 20 bits
  localparam int POW_BITS    = 20;
  localparam int PROD_BITS   = VALUE_BITS + POW_BITS;
  localparam int CAND_BITS   = VALUE_BITS + 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_INT,
    PH_FRAC,
    PH_TRAIL,
    PH_END,
    PH_BAD
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  // parser state after the current byte, handed to the scaling stage
  typedef struct packed {
    logic                  bad;
    logic                  digit_seen;
    logic                  negative;
    logic                  saturated;
    logic [VALUE_BITS-1:0] magnitude;
    logic [FRAC_BITS-1:0]  frac_count;
  } parse_snap_t;

  function automatic logic [VALUE_BITS-1:0] mag_limit(input logic neg);
    logic [VALUE_BITS-1:0] top;
    top = VALUE_BITS'(1) << (VALUE_BITS - 1);
    return neg ? top : top - VALUE_BITS'(1);
  endfunction

  function automatic logic [POW_BITS-1:0] pow10(input logic [FRAC_BITS-1:0] n);
    logic [POW_BITS-1:0] p;
    p = POW_BITS'(1);
    for (int k = 0; k < FRAC_PLACES; k++) begin
      if (k < int'(n)) p = POW_BITS'(p * 10);
    end
    return p;
  endfunction

endpackage

### rtl/core/dstf_parse.sv
module dstf_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           char_byte,
  input  logic                 last,
  output dstf_pkg::parse_snap_t snap
);
  import dstf_pkg::*;

  phase_t                phase, phase_next;
  logic                  negative, negative_next;
  logic [VALUE_BITS-1:0] magnitude, magnitude_next;
  logic [FRAC_BITS-1:0]  frac_count, frac_count_next;
  logic                  digit_seen, digit_seen_next;
  logic                  saturated, saturated_next;

  logic                  dig, ws, take, take_frac, keep_frac;
  logic [CAND_BITS-1:0]  cand;
  logic [VALUE_BITS-1:0] lim;

  always_comb begin
    dig = (char_byte inside {[CH_ZERO:CH_NINE]});
    ws  = (char_byte == CH_SPACE) || (char_byte inside {[CH_TAB:CH_CR]});
  end

  // phase transitions and which bytes count as kept digits
  always_comb begin
    phase_next    = phase;
    negative_next = negative;
    take          = 1'b0;
    take_frac     = 1'b0;
    if (phase == PH_END || phase == PH_BAD) begin
      phase_next = phase;
    end else if (char_byte == CH_NUL) begin
      phase_next = PH_END;
    end else begin
      case (phase)
        PH_LEAD, PH_SIGN, PH_INT: begin
          if (phase == PH_LEAD && ws) begin
            phase_next = PH_LEAD;
          end else if (phase == PH_LEAD &&
                       (char_byte == CH_PLUS || char_byte == CH_MINUS)) begin
            negative_next = (char_byte == CH_MINUS);
            phase_next    = PH_SIGN;
          end else if (dig) begin
            take       = 1'b1;
            phase_next = PH_INT;
          end else if (char_byte == CH_POINT) begin
            phase_next = PH_FRAC;
          end else if (phase == PH_INT && ws) begin
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_FRAC: begin
          if (dig) begin
            take_frac = 1'b1;
          end else if (ws) begin
            phase_next = PH_TRAIL;
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_TRAIL: begin
          if (!ws) phase_next = PH_BAD;
        end
        default: begin
          phase_next = PH_BAD;
        end
      endcase
    end
  end

  // digit accumulation with saturation
  always_comb begin
    magnitude_next  = magnitude;
    frac_count_next = frac_count;
    digit_seen_next = digit_seen;
    saturated_next  = saturated;
    lim  = mag_limit(negative);
    cand = (CAND_BITS'(magnitude) << 3) + (CAND_BITS'(magnitude) << 1)
         + CAND_BITS'(char_byte[3:0]);
    if (take || take_frac) digit_seen_next = 1'b1;
    // extra fraction digits are checked but dropped
    keep_frac = take_frac && (32'(frac_count) < 32'(FRAC_PLACES));
    if (keep_frac) frac_count_next = frac_count + FRAC_BITS'(1);
    if ((take || keep_frac) && !saturated) begin
      if (cand > CAND_BITS'(lim)) begin
        saturated_next = 1'b1;
        magnitude_next = lim;
      end else begin
        magnitude_next = cand[VALUE_BITS-1:0];
      end
    end
  end

  always_comb begin
    snap.bad        = (phase_next == PH_BAD);
    snap.digit_seen = digit_seen_next;
    snap.negative   = negative_next;
    snap.saturated  = saturated_next;
    snap.magnitude  = magnitude_next;
    snap.frac_count = frac_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      phase      <= PH_LEAD;
      negative   <= 1'b0;
      magnitude  <= '0;
      frac_count <= '0;
      digit_seen <= 1'b0;
      saturated  <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      negative   <= negative_next;
      magnitude  <= magnitude_next;
      frac_count <= frac_count_next;
      digit_seen <= digit_seen_next;
      saturated  <= saturated_next;
    end
  end

endmodule

### rtl/core/dstf_scale.sv
module dstf_scale (
  input  dstf_pkg::parse_snap_t snap,
  output dstf_pkg::status_t     status,
  output logic signed [31:0]    value
);
  import dstf_pkg::*;

  logic [FRAC_BITS-1:0]  missing;
  logic [PROD_BITS-1:0]  prod;
  logic [VALUE_BITS-1:0] lim, mag, signed_mag;
  logic                  sat;

  always_comb begin
    missing = FRAC_BITS'(FRAC_PLACES) - snap.frac_count;
    lim     = mag_limit(snap.negative);
    // one multiply by 10^missing stands in for the per-place scaling
    prod    = PROD_BITS'(snap.magnitude) * PROD_BITS'(pow10(missing));
    sat     = snap.saturated;
    mag     = snap.magnitude;
    if (!snap.saturated) begin
      if (prod > PROD_BITS'(lim)) begin
        sat = 1'b1;
        mag = lim;
      end else begin
        mag = prod[VALUE_BITS-1:0];
      end
    end
    signed_mag = snap.negative ? (VALUE_BITS'(0) - mag) : mag;
    if (snap.bad || !snap.digit_seen) begin
      status = ST_MALFORMED;
      value  = '0;
    end else begin
      status = sat ? ST_SATURATED : ST_OK;
      value  = 32'(signed_mag);
    end
  end

endmodule

### rtl/core/decimal_string_to_fixed.sv
// channel | dir | tdata bits (low first)            | tlast
// s_*     | in  | [7:0] char_byte                     | last
// m_*     | out | [1:0] status, [33:2] value, 0 fill  | -
//
// one byte per cycle sustained; each beat passes an input register, then the
// parse update and the final scaling multiply land in the result register
// m_tvalid rises as the beat with tlast advances out of the input register
// rst is synchronous and returns the parser to the leading whitespace phase
// a held result stalls a tlast beat and those behind it; other beats flow on
`include "decimal_string_to_fixed_defines.svh"

module decimal_string_to_fixed (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [1:0] status, [33:2] value, [39:34] zero
);
  import dstf_pkg::*;

  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              adv;
  parse_snap_t       snap;
  status_t           status;
  logic signed [31:0] value;

  assign adv      = s1_valid && (!s1_last || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_byte <= s_tdata;
      s1_last <= s_tlast;
    end
  end

  dstf_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (adv),
    .char_byte (s1_byte),
    .last      (s1_last),
    .snap      (snap)
  );

  dstf_scale u_scale (
    .snap   (snap),
    .status (status),
    .value  (value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && s1_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last) begin
      m_tdata <= {6'b0, value, status};
    end
  end

  `DSTF_CHECK(a_out_from_last, $rose(m_tvalid) |-> $past(adv && s1_last))
  `DSTF_CHECK(a_s1_holds, s1_valid && !adv |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
  `DSTF_CHECK(a_malformed_zero, m_tvalid && m_tdata[1:0] == ST_MALFORMED |-> m_tdata[33:2] == 32'd0)
  `DSTF_CHECK_ALWAYS(a_reset_empty, rst |=> !s1_valid && !m_tvalid)

endmodule

### tb/tb_decimal_string_to_fixed.sv
`timescale 1ns / 100ps

module tb_decimal_string_to_fixed;
  import dstf_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
  } fixed_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] char_byte
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [1:0] status, [33:2] value, [39:34] zero

  decimal_string_to_fixed dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // parser state mirrored on the bench side
  phase_t      parse_phase;
  logic        acc_negative;
  logic [63:0] acc_magnitude;
  int          frac_kept;
  logic        acc_digit_seen;
  logic        acc_saturated;

  fixed_result_t expected_results[$];
  fixed_result_t oldest;
  logic [7:0]    pending_chars[$];

  bit sender_gaps;
  bit ready_stalls;
  int mismatches;
  int bytes_sent;
  int strings_sent;
  int results_checked;
  int saturated_seen;
  int malformed_seen;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [63:0] mag_ceiling();
    return (64'd1 << (VALUE_BITS - 1)) - (acc_negative ? 64'd0 : 64'd1);
  endfunction

  function automatic void clear_accumulator();
    parse_phase    = PH_LEAD;
    acc_negative   = 1'b0;
    acc_magnitude  = '0;
    frac_kept      = 0;
    acc_digit_seen = 1'b0;
    acc_saturated  = 1'b0;
  endfunction

  function automatic void take_digit(input logic [3:0] d);
    logic [63:0] lim;
    lim = mag_ceiling();
    acc_digit_seen = 1'b1;
    if (!acc_saturated) begin
      if (acc_magnitude > (lim - 64'(d)) / 10) begin
        acc_saturated = 1'b1;
        acc_magnitude = lim;
      end else begin
        acc_magnitude = acc_magnitude * 10 + 64'(d);
      end
    end
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic       dig;
    logic [3:0] d;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    d   = 4'(c - CH_ZERO);
    if (parse_phase == PH_END || parse_phase == PH_BAD) return;
    if (c == CH_NUL) begin
      parse_phase = PH_END;
      return;
    end
    if (parse_phase == PH_LEAD && is_blank(c)) return;
    if (parse_phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
      acc_negative = (c == CH_MINUS);
      parse_phase  = PH_SIGN;
      return;
    end
    case (parse_phase)
      PH_LEAD, PH_SIGN, PH_INT: begin
        if (dig) begin
          take_digit(d);
          parse_phase = PH_INT;
        end else if (c == CH_POINT) begin
          parse_phase = PH_FRAC;
        end else if (parse_phase == PH_INT && is_blank(c)) begin
          parse_phase = PH_TRAIL;
        end else begin
          parse_phase = PH_BAD;
        end
      end
      PH_FRAC: begin
        if (dig) begin
          // digits past the kept places only count as seen
          if (frac_kept < FRAC_PLACES) begin
            take_digit(d);
            frac_kept++;
          end else begin
            acc_digit_seen = 1'b1;
          end
        end else if (is_blank(c)) begin
          parse_phase = PH_TRAIL;
        end else begin
          parse_phase = PH_BAD;
        end
      end
      PH_TRAIL: begin
        if (!is_blank(c)) parse_phase = PH_BAD;
      end
      default: parse_phase = PH_BAD;
    endcase
  endfunction

  function automatic void predict_beat(input logic [7:0] c, input logic l);
    fixed_result_t r;
    logic [63:0]   m;
    parse_char(c);
    if (!l) return;
    if (parse_phase == PH_BAD || !acc_digit_seen) begin
      r.status = ST_MALFORMED;
      r.value  = '0;
    end else begin
      // scale up for the fraction places that never arrived
      for (int k = frac_kept; k < FRAC_PLACES; k++) begin
        if (!acc_saturated) begin
          if (acc_magnitude > mag_ceiling() / 10) begin
            acc_saturated = 1'b1;
            acc_magnitude = mag_ceiling();
          end else begin
            acc_magnitude = acc_magnitude * 10;
          end
        end
      end
      r.status = acc_saturated ? ST_SATURATED : ST_OK;
      m = acc_negative ? (64'd0 - acc_magnitude) : acc_magnitude;
      r.value = m[31:0];
    end
    expected_results.push_back(r);
    clear_accumulator();
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic l);
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_beat(c, l);
    bytes_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
  endtask

  task automatic send_pending();
    int n;
    n = pending_chars.size();
    for (int i = 0; i < n; i++) send_byte(pending_chars[i], i == n - 1);
    pending_chars.delete();
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    push_text(s);
    send_pending();
  endtask

  function automatic logic [7:0] pick_blank();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // number-like text with random content into pending_chars; with no digit it is malformed
  task automatic build_number();
    int n;
    repeat ($urandom_range(0, 2)) pending_chars.push_back(pick_blank());
    case ($urandom_range(0, 2))
      1: pending_chars.push_back(CH_PLUS);
      2: pending_chars.push_back(CH_MINUS);
      default: ;
    endcase
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : $urandom_range(0, 4);
    repeat (n) pending_chars.push_back(pick_digit());
    if ($urandom_range(0, 1) == 1) begin
      pending_chars.push_back(CH_POINT);
      repeat ($urandom_range(0, 4)) pending_chars.push_back(pick_digit());
    end
    repeat ($urandom_range(0, 2)) pending_chars.push_back(pick_blank());
  endtask

  task automatic test_well_formed();
    send_text("0");
    send_text("9");
    send_text("+0.5");
    send_text("-12.345");
    send_text("\011 42\015\012 ");
    send_text("7.");
    send_text(".25");
    send_text("\013\01400012.3\014");
    send_text("-0.001");
  endtask

  task automatic test_malformed();
    send_text("-");
    send_text(".");
    send_text("   ");
    send_text("+ 5");
    send_text("1..2");
    send_text("+-3");
    send_text("12 3");
    send_text("1a");
    send_text("5 -");
    pending_chars.push_back(8'hFF);
    send_pending();
  endtask

  task automatic test_string_end();
    // terminator alone is an empty string
    pending_chars.push_back(CH_NUL);
    send_pending();
    push_text("12");
    pending_chars.push_back(CH_NUL);
    push_text("x-.");
    pending_chars.push_back(8'hFF);
    send_pending();
    push_text("-3.5 ");
    pending_chars.push_back(CH_NUL);
    pending_chars.push_back(CH_NUL);
    send_pending();
  endtask

  task automatic test_overflow();
    send_text("21474836.47");
    send_text("21474836.48");
    send_text("-21474836.48");
    send_text("-21474836.49");
    send_text("21474837");
    send_text("-2147483647");
    send_text("99999999999.999");
  endtask

  task automatic test_random_strings(input int n_bytes);
    int stop_at;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 9))
        7: begin
          // built number with one byte replaced by anything, or one random byte if it is empty
          build_number();
          if (pending_chars.size() == 0) pending_chars.push_back(8'($urandom_range(0, 255)));
          else pending_chars[$urandom_range(0, pending_chars.size() - 1)] =
              8'($urandom_range(0, 255));
        end
        8: repeat ($urandom_range(1, 6)) pending_chars.push_back(8'($urandom_range(0, 255)));
        9: begin
          build_number();
          pending_chars.push_back(CH_NUL);
          repeat ($urandom_range(0, 4)) pending_chars.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          build_number();
          if (pending_chars.size() == 0) pending_chars.push_back(pick_digit());
        end
      endcase
      send_pending();
    end
  endtask

  task automatic test_full_rate(input int n_bytes);
    sender_gaps  = 1'b0;
    ready_stalls = 1'b0;
    test_random_strings(n_bytes);
  endtask

  // result sink with random backpressure while ready_stalls is set
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (ready_stalls && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: status %0d value %0d",
               m_tdata[1:0], $signed(m_tdata[33:2]));
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        results_checked++;
        if (oldest.status == ST_SATURATED) saturated_seen++;
        if (oldest.status == ST_MALFORMED) malformed_seen++;
        if (m_tdata[1:0] !== oldest.status) begin
          $error("status mismatch: expected %0d, got %0d", oldest.status, m_tdata[1:0]);
          mismatches++;
        end
        if (m_tdata[33:2] !== oldest.value) begin
          $error("value mismatch: expected %0d, got %0d",
                 $signed(oldest.value), $signed(m_tdata[33:2]));
          mismatches++;
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    sender_gaps  = 1'b1;
    ready_stalls = 1'b1;
    mismatches   = 0;
    bytes_sent   = 0;
    strings_sent = 0;
    results_checked = 0;
    saturated_seen  = 0;
    malformed_seen  = 0;
    clear_accumulator();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_well_formed();
    test_malformed();
    test_string_end();
    test_overflow();
    test_random_strings(200);
    test_full_rate(90);

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d bytes in %0d strings, checked %0d results", bytes_sent,
             strings_sent, results_checked);
    $display("of those %0d saturated and %0d malformed", saturated_seen, malformed_seen);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
